// ===== rtl/rkv_pkg.sv =====
// shared types, codes and default sizes for the rotary embedding cache prep block
`timescale 1ns / 1ps
`default_nettype none

package rkv_pkg;

    localparam int DEF_HEAD_DIM     = 128;
    localparam int DEF_QUERY_HEADS  = 16;
    localparam int DEF_KV_HEADS     = 2;
    localparam int DEF_CACHE_LENGTH = 1024;
    localparam int DEF_QUEUE_DEPTH  = 4;

    localparam int POS_W  = 10;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int ADDR_W = 18;
    localparam int ROW_W  = 9;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_MASK = 2'd2;

    localparam logic [1:0] SEC_QUERY = 2'd0;
    localparam logic [1:0] SEC_KEY   = 2'd1;
    localparam logic [1:0] SEC_VALUE = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    row_we;
        logic [ROW_W-1:0]        row_index;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic [1:0]              section;
        logic [3:0]              head_number;
        logic [5:0]              pair_index;
        logic                    cache_write;
        logic [ADDR_W-1:0]       cache_address;
        logic                    mask_byte;
        logic                    last;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/rkv_front.sv =====
// front end: accepts words, tracks the packed pair stream and classifies each word
`timescale 1ns / 1ps
`default_nettype none

module rkv_front #(
    parameter int HEAD_DIM     = rkv_pkg::DEF_HEAD_DIM,
    parameter int QUERY_HEADS  = rkv_pkg::DEF_QUERY_HEADS,
    parameter int KV_HEADS     = rkv_pkg::DEF_KV_HEADS,
    parameter int CACHE_LENGTH = rkv_pkg::DEF_CACHE_LENGTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rkv_pkg::POS_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [rkv_pkg::IDX_W-1:0]   i_index,
    input  wire logic signed [rkv_pkg::VAL_W-1:0] i_value_a,
    input  wire logic signed [rkv_pkg::VAL_W-1:0] i_value_b,
    output logic                             o_push_valid,
    input  wire logic                        i_push_ready,
    output rkv_pkg::t_cmd                    o_cmd
);
    import rkv_pkg::*;

    localparam int HALF   = HEAD_DIM / 2;
    localparam int MAXH   = (QUERY_HEADS > KV_HEADS) ? QUERY_HEADS : KV_HEADS;
    localparam int HW     = (MAXH > 1) ? $clog2(MAXH) : 1;
    localparam int PW     = (HALF > 1) ? $clog2(HALF) : 1;
    localparam logic [ADDR_W-1:0] HEAD_STRIDE = ADDR_W'(CACHE_LENGTH * HEAD_DIM);

    logic [1:0]        r_sec;
    logic [HW-1:0]     r_head;
    logic [PW-1:0]     r_pidx;
    logic [ADDR_W-1:0] r_head_base;
    logic [POS_W-1:0]  r_pos;
    logic [ADDR_W-1:0] r_pos_off;
    logic              r_pos_ok;

    logic [1:0]        n_sec;
    logic [HW-1:0]     n_head;
    logic [PW-1:0]     n_pidx;
    logic [ADDR_W-1:0] n_head_base;

    logic w_acc;
    logic w_acc_data;
    logic w_p_end;
    logic w_h_end;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign w_acc        = i_in_valid && i_push_ready;
    assign w_acc_data   = w_acc && (i_opcode == KIND_DATA);

    assign w_p_end = (r_pidx == PW'(HALF - 1));
    assign w_h_end = (r_sec == SEC_QUERY) ? (r_head == HW'(QUERY_HEADS - 1))
                                          : (r_head == HW'(KV_HEADS - 1));

    always_comb begin
        n_sec       = r_sec;
        n_head      = r_head;
        n_pidx      = r_pidx + PW'(1);
        n_head_base = r_head_base;
        if (w_p_end) begin
            n_pidx = '0;
            if (w_h_end) begin
                n_head      = '0;
                n_head_base = '0;
                case (r_sec)
                    SEC_QUERY: n_sec = SEC_KEY;
                    SEC_KEY:   n_sec = SEC_VALUE;
                    default:   n_sec = SEC_QUERY;
                endcase
            end else begin
                n_head      = r_head + HW'(1);
                n_head_base = r_head_base + HEAD_STRIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= SEC_QUERY;
            r_head      <= '0;
            r_pidx      <= '0;
            r_head_base <= '0;
            r_pos       <= '0;
            r_pos_off   <= '0;
            r_pos_ok    <= 1'b1;
        end else begin
            if (w_acc_data) begin
                r_sec       <= n_sec;
                r_head      <= n_head;
                r_pidx      <= n_pidx;
                r_head_base <= n_head_base;
            end
            if (i_cfg_valid) begin
                r_pos     <= i_cfg_data;
                r_pos_off <= ADDR_W'(i_cfg_data) * ADDR_W'(HEAD_DIM);
                r_pos_ok  <= (17'(i_cfg_data) < 17'(CACHE_LENGTH));
            end
        end
    end

    always_comb begin
        o_cmd               = '0;
        o_cmd.kind          = i_opcode;
        o_cmd.value_a       = i_value_a;
        o_cmd.value_b       = i_value_b;
        case (i_opcode)
            KIND_LOAD: begin
                o_cmd.row_we    = (11'(i_index) < 11'(HEAD_DIM));
                o_cmd.row_index = ROW_W'(i_index);
            end
            KIND_DATA: begin
                o_cmd.row_index   = ROW_W'(r_pidx);
                o_cmd.section     = r_sec;
                o_cmd.head_number = 4'(r_head);
                o_cmd.pair_index  = 6'(r_pidx);
                o_cmd.cache_write = (r_sec != SEC_QUERY) && r_pos_ok;
                if (o_cmd.cache_write) begin
                    o_cmd.cache_address = r_head_base + r_pos_off + ADDR_W'(r_pidx);
                end
                o_cmd.last = (r_sec == SEC_VALUE) && w_h_end && w_p_end;
            end
            KIND_MASK: begin
                o_cmd.mask_byte = !((17'(i_index) < 17'(CACHE_LENGTH)) &&
                                    (i_index <= r_pos));
            end
            default: begin
                o_cmd.value_a = '0;
                o_cmd.value_b = '0;
            end
        endcase
    end

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_data && o_cmd.last |=> r_sec == SEC_QUERY && r_head == '0 && r_pidx == '0)
        else $error("pair stream did not wrap after last pair");

    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cache_write |-> o_cmd.kind == KIND_DATA && o_cmd.section != SEC_QUERY)
        else $error("cache write on a word that is not a key or value pair");

endmodule

`default_nettype wire

// ===== rtl/rkv_fifo.sv =====
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none

module rkv_fifo #(
    parameter int DEPTH = rkv_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire rkv_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output rkv_pkg::t_cmd      o_pop_cmd
);
    import rkv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + CW'(1))
        else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ===== rtl/rkv_back.sv =====
// back end: factor rows, rotation pipeline and output register
`timescale 1ns / 1ps
`default_nettype none

module rkv_back #(
    parameter int HEAD_DIM = rkv_pkg::DEF_HEAD_DIM
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop_valid,
    output logic               o_pop_ready,
    input  wire rkv_pkg::t_cmd i_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic signed [rkv_pkg::VAL_W-1:0] o_out_lo,
    output logic signed [rkv_pkg::VAL_W-1:0] o_out_hi,
    output logic [1:0]         o_section,
    output logic [3:0]         o_head_number,
    output logic [5:0]         o_pair_index,
    output logic               o_cache_write,
    output logic [rkv_pkg::ADDR_W-1:0] o_cache_address,
    output logic               o_mask_byte,
    output logic               o_last
);
    import rkv_pkg::*;

    localparam int AW   = $clog2(HEAD_DIM);
    localparam int HALF = HEAD_DIM / 2;

    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [32:0] s);
        logic signed [33:0] t;
        logic signed [19:0] q;
        t = 34'(s) + 34'sd8192;
        q = t[33:14];
        if (q > 20'sd32767) begin
            round_sat = 16'sh7fff;
        end else if (q < -20'sd32768) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[15:0];
        end
    endfunction

    logic signed [VAL_W-1:0] r_cos_mem [HEAD_DIM];
    logic signed [VAL_W-1:0] r_sin_mem [HEAD_DIM];

    logic                    r_v1;
    t_cmd                    r_c1;
    logic signed [VAL_W-1:0] r_cos_lo;
    logic signed [VAL_W-1:0] r_sin_lo;
    logic signed [VAL_W-1:0] r_cos_hi;
    logic signed [VAL_W-1:0] r_sin_hi;

    logic                    r_v2;
    t_cmd                    r_c2;
    logic signed [31:0]      r_a_cos;
    logic signed [31:0]      r_b_sin;
    logic signed [31:0]      r_b_cos;
    logic signed [31:0]      r_a_sin;

    logic                    r_v3;

    logic          w_adv;
    logic          w_pop;
    logic [AW-1:0] w_lo_addr;
    logic [AW-1:0] w_hi_addr;
    logic          w_rot;
    logic          w_pass;

    assign w_adv       = !r_v3 || i_out_ready;
    assign o_pop_ready = w_adv;
    assign w_pop       = i_pop_valid && w_adv;
    assign w_lo_addr   = i_cmd.row_index[AW-1:0];
    assign w_hi_addr   = i_cmd.row_index[AW-1:0] + AW'(HALF);
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.kind == KIND_LOAD && i_cmd.row_we) begin
            r_cos_mem[w_lo_addr] <= i_cmd.value_a;
            r_sin_mem[w_lo_addr] <= i_cmd.value_b;
        end
        if (w_adv) begin
            r_cos_lo <= r_cos_mem[w_lo_addr];
            r_sin_lo <= r_sin_mem[w_lo_addr];
            r_cos_hi <= r_cos_mem[w_hi_addr];
            r_sin_hi <= r_sin_mem[w_hi_addr];
        end
    end

    assign w_rot  = (r_c2.kind == KIND_DATA) && (r_c2.section != SEC_VALUE);
    assign w_pass = (r_c2.kind == KIND_DATA) && (r_c2.section == SEC_VALUE);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1    <= i_cmd;
            r_c2    <= r_c1;
            r_a_cos <= 32'(r_c1.value_a) * 32'(r_cos_lo);
            r_b_sin <= 32'(r_c1.value_b) * 32'(r_sin_lo);
            r_b_cos <= 32'(r_c1.value_b) * 32'(r_cos_hi);
            r_a_sin <= 32'(r_c1.value_a) * 32'(r_sin_hi);

            o_kind          <= r_c2.kind;
            o_section       <= r_c2.section;
            o_head_number   <= r_c2.head_number;
            o_pair_index    <= r_c2.pair_index;
            o_cache_write   <= r_c2.cache_write;
            o_cache_address <= r_c2.cache_address;
            o_mask_byte     <= r_c2.mask_byte;
            o_last          <= r_c2.last;
            if (w_rot) begin
                o_out_lo <= round_sat(33'(r_a_cos) - 33'(r_b_sin));
                o_out_hi <= round_sat(33'(r_b_cos) + 33'(r_a_sin));
            end else if (w_pass) begin
                o_out_lo <= r_c2.value_a;
                o_out_hi <= r_c2.value_b;
            end else begin
                o_out_lo <= '0;
                o_out_hi <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_pop_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    a_zero_elems: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_out_lo == '0 && o_out_hi == '0)
        else $error("element fields not cleared on a non-pair word");

endmodule

`default_nettype wire

// ===== rtl/rope_kv_cache_prep.sv =====
// top level of the rotary embedding and cache address prep block
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per cycle while the queue has room and returns one word per word
// taken, in order. Load words fill the cosine and sine rows, pair words stream
// query, key and value pairs in packed order; query and key pairs are rotated with
// rounding and saturation, value pairs pass unchanged, key and value pairs carry
// their cache address while the position is in range, and mask words return the
// mask bit for a position. A word goes through the classifying front end into a
// four entry queue, then through a three stage back end (row read, four parallel
// 16x16 multiplies, sum with round and saturate into the output register). The
// cache position register is written on the cfg channel, which is always ready;
// write it only while the block is empty.
module rope_kv_cache_prep #(
    parameter int HEAD_DIM     = rkv_pkg::DEF_HEAD_DIM,
    parameter int QUERY_HEADS  = rkv_pkg::DEF_QUERY_HEADS,
    parameter int KV_HEADS     = rkv_pkg::DEF_KV_HEADS,
    parameter int CACHE_LENGTH = rkv_pkg::DEF_CACHE_LENGTH,
    parameter int QUEUE_DEPTH  = rkv_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rkv_pkg::POS_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [rkv_pkg::IDX_W-1:0]         i_index,
    input  wire logic signed [rkv_pkg::VAL_W-1:0]  i_value_a,
    input  wire logic signed [rkv_pkg::VAL_W-1:0]  i_value_b,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_kind,
    output logic signed [rkv_pkg::VAL_W-1:0]       o_out_lo,
    output logic signed [rkv_pkg::VAL_W-1:0]       o_out_hi,
    output logic [1:0]                             o_section,
    output logic [3:0]                             o_head_number,
    output logic [5:0]                             o_pair_index,
    output logic                                   o_cache_write,
    output logic [rkv_pkg::ADDR_W-1:0]             o_cache_address,
    output logic                                   o_mask_byte,
    output logic                                   o_last
);
    import rkv_pkg::*;

    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;

    rkv_front #(
        .HEAD_DIM     (HEAD_DIM),
        .QUERY_HEADS  (QUERY_HEADS),
        .KV_HEADS     (KV_HEADS),
        .CACHE_LENGTH (CACHE_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_index      (i_index),
        .i_value_a    (i_value_a),
        .i_value_b    (i_value_b),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_push_cmd)
    );

    rkv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    rkv_back #(
        .HEAD_DIM (HEAD_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop_valid     (w_pop_valid),
        .o_pop_ready     (w_pop_ready),
        .i_cmd           (w_pop_cmd),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_out_lo        (o_out_lo),
        .o_out_hi        (o_out_hi),
        .o_section       (o_section),
        .o_head_number   (o_head_number),
        .o_pair_index    (o_pair_index),
        .o_cache_write   (o_cache_write),
        .o_cache_address (o_cache_address),
        .o_mask_byte     (o_mask_byte),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
